>>> hw/rtl/fepc_pkg.sv
// Shared types and constants for the filtered edge pulse counter.
`timescale 1ns / 1ps
package fepc_pkg;

  localparam int COUNT_WIDTH    = 32;
  localparam int TIME_WIDTH     = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int RATE_WIDTH     = 48;
  localparam int RATE_NUM_WIDTH = 24;
  localparam int NUM_WIDTH      = COUNT_WIDTH + RATE_NUM_WIDTH;
  localparam int IN_DATA_WIDTH  = 40;
  localparam int OUT_DATA_WIDTH = 112;

  // 60000 pulses/min scale times 256 for the q8 fraction
  localparam logic [RATE_NUM_WIDTH-1:0] RATE_NUM = RATE_NUM_WIDTH'(15360000);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_INC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_RISING_MODE  = 3'd0,
    CFG_FALLING_MODE = 3'd1,
    CFG_MIN_GAP_US   = 3'd2,
    CFG_INTERVAL_MS  = 3'd3,
    CFG_TOTAL_ENABLE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           rising_mode;
    logic [1:0]           falling_mode;
    logic [CFG_WIDTH-1:0] min_gap_us;
    logic [CFG_WIDTH-1:0] interval_ms;
    logic                 total_enable;
  } cfg_t;

  // One read job handed from the front to the rate unit
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] delta;
    logic [COUNT_WIDTH-1:0] total;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/fepc_front.sv
// Front end: accepts items, filters edges, keeps counters, issues read jobs.
`timescale 1ns / 1ps
module fepc_front
  import fepc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic                  pin_level_i,
  input  logic [TIME_WIDTH-1:0] time_us_i,
  input  queue_status_t         queue_status_i,
  output logic                  push_o,
  output job_t                  job_o
);

  logic [TIME_WIDTH-1:0]  last_edge_q, last_edge_d;
  logic [COUNT_WIDTH-1:0] pulse_count_q, pulse_count_d;
  logic [COUNT_WIDTH-1:0] count_at_read_q, count_at_read_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [TIME_WIDTH-1:0]  gap;
  logic                   discard;
  logic [1:0]             mode;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] delta;

  assign in_ready_o = !queue_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    gap     = time_us_i - last_edge_q;
    discard = CFG_WIDTH'(gap) < cfg_i.min_gap_us;
    mode    = pin_level_i ? cfg_i.rising_mode : cfg_i.falling_mode;
    delta   = pulse_count_q - count_at_read_q;

    last_edge_d     = last_edge_q;
    pulse_count_d   = pulse_count_q;
    count_at_read_d = count_at_read_q;
    total_d         = total_q;

    if (accept) begin
      if (opcode_i == OP_EDGE) begin
        // the stored edge time moves even for a filtered edge
        last_edge_d = time_us_i;
        if (!discard) begin
          case (mode)
            MODE_INC: pulse_count_d = pulse_count_q + COUNT_WIDTH'(1);
            MODE_DEC: pulse_count_d = pulse_count_q - COUNT_WIDTH'(1);
            default:  pulse_count_d = pulse_count_q;
          endcase
        end
      end else begin
        count_at_read_d = pulse_count_q;
        if (cfg_i.total_enable) begin
          total_d = total_q + delta;
        end
      end
    end
  end

  assign push_o      = accept && (opcode_i == OP_READ);
  assign job_o.delta = delta;
  assign job_o.total = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q     <= '0;
      pulse_count_q   <= '0;
      count_at_read_q <= '0;
      total_q         <= '0;
    end else begin
      last_edge_q     <= last_edge_d;
      pulse_count_q   <= pulse_count_d;
      count_at_read_q <= count_at_read_d;
      total_q         <= total_d;
    end
  end

endmodule

>>> hw/rtl/fepc_queue.sv
// Two-entry job queue between the front end and the rate unit.
`timescale 1ns / 1ps
module fepc_queue
  import fepc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          push_data_i,
  input  logic          pop_i,
  output job_t          pop_data_o,
  output queue_status_t status_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push;
  logic       do_pop;

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

>>> hw/rtl/fepc_back.sv
// Back end: scales delta to a q8 rate with a bit-serial divider, drives results.
`timescale 1ns / 1ps
module fepc_back
  import fepc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [CFG_WIDTH-1:0]      interval_ms_i,
  input  queue_status_t             queue_status_i,
  input  job_t                      job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               delta_count_o,
  output logic [RATE_WIDTH-1:0]     rate_q8_o,
  output logic [31:0]               running_total_o
);

  localparam int CNT_WIDTH = $clog2(NUM_WIDTH);
  localparam logic [63:0] MAG_MIN = 64'd1 << (RATE_WIDTH - 1);
  localparam logic [63:0] MAG_MAX = MAG_MIN - 64'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [COUNT_WIDTH-1:0] delta_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic                   neg_q;
  logic [COUNT_WIDTH-1:0] mag_q;
  logic [NUM_WIDTH-1:0]   num_q;
  logic [CFG_WIDTH-1:0]   rem_q;
  logic [CNT_WIDTH-1:0]   cnt_q;
  logic                   out_valid_q;
  logic [31:0]            delta_out_q;
  logic [RATE_WIDTH-1:0]  rate_out_q;
  logic [31:0]            total_out_q;

  logic [CFG_WIDTH:0]     trial;
  logic                   ge;
  logic [CFG_WIDTH-1:0]   rem_next;
  logic [63:0]            quot;
  logic [63:0]            quot_sat;
  logic [RATE_WIDTH-1:0]  rate;
  logic                   job_neg;
  logic [COUNT_WIDTH-1:0] job_mag;
  logic                   load_out;

  always_comb begin
    // restoring divide step, one quotient bit per cycle
    trial    = {rem_q, num_q[NUM_WIDTH-1]};
    ge       = trial >= {1'b0, interval_ms_i};
    rem_next = ge ? CFG_WIDTH'(trial - {1'b0, interval_ms_i}) : trial[CFG_WIDTH-1:0];

    // zero interval leaves an all-ones quotient, which saturates below
    quot = (mag_q == '0) ? 64'd0 : 64'(num_q);
    if (neg_q) begin
      quot_sat = (quot > MAG_MIN) ? MAG_MIN : quot;
      rate     = RATE_WIDTH'(-quot_sat);
    end else begin
      quot_sat = (quot > MAG_MAX) ? MAG_MAX : quot;
      rate     = quot_sat[RATE_WIDTH-1:0];
    end

    job_neg = job_i.delta[COUNT_WIDTH-1];
    job_mag = job_neg ? -job_i.delta : job_i.delta;
  end

  assign pop_o    = (state_q == ST_IDLE) && !queue_status_i.empty;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      delta_q     <= '0;
      total_q     <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      delta_out_q <= '0;
      rate_out_q  <= '0;
      total_out_q <= '0;
    end else begin
      if (out_ready_i && !load_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!queue_status_i.empty) begin
            delta_q <= job_i.delta;
            total_q <= job_i.total;
            neg_q   <= job_neg;
            mag_q   <= job_mag;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          num_q   <= NUM_WIDTH'(mag_q) * NUM_WIDTH'(RATE_NUM);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= rem_next;
          num_q <= {num_q[NUM_WIDTH-2:0], ge};
          cnt_q <= cnt_q + CNT_WIDTH'(1);
          if (cnt_q == CNT_WIDTH'(NUM_WIDTH - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            delta_out_q <= 32'($signed(delta_q));
            rate_out_q  <= rate;
            total_out_q <= 32'($signed(total_q));
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign delta_count_o   = delta_out_q;
  assign rate_q8_o       = rate_out_q;
  assign running_total_o = total_out_q;

endmodule

>>> hw/rtl/filtered_edge_pulse_counter_top.sv
// Top level of the filtered edge pulse counter: config registers and stream ports.
// Flow: an edge item is absorbed in the cycle it is accepted and gives no result;
//   a read item passes the job queue and the rate unit's load, multiply, divide, done steps.
// Throughput: one edge item per cycle; the bit-serial rate divider takes the next read
//   only once the last is done; a 2-entry queue absorbs reads, all input stalls when full.
// Reset: counters, edge time and total clear to zero, config takes its default values.
`timescale 1ns / 1ps
module filtered_edge_pulse_counter_top
  import fepc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]      cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,  // [0] pin_level, [32:1] time_us, rest 0
  input  logic                      s_axis_tuser,  // [0] opcode (0 edge, 1 read)
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata   // [31:0] delta_count,
                                                   // [79:32] rate_q8,
                                                   // [111:80] running_total
);

  cfg_t          cfg_q;
  queue_status_t queue_status;
  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          pop_job;
  logic [31:0]           delta_count;
  logic [RATE_WIDTH-1:0] rate_q8;
  logic [31:0]           running_total;

  // Config registers; software writes them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rising_mode  <= MODE_INC;
      cfg_q.falling_mode <= MODE_NONE;
      cfg_q.min_gap_us   <= CFG_WIDTH'(13);
      cfg_q.interval_ms  <= CFG_WIDTH'(60000);
      cfg_q.total_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RISING_MODE:  cfg_q.rising_mode  <= cfg_wdata_i[1:0];
        CFG_FALLING_MODE: cfg_q.falling_mode <= cfg_wdata_i[1:0];
        CFG_MIN_GAP_US:   cfg_q.min_gap_us   <= cfg_wdata_i;
        CFG_INTERVAL_MS:  cfg_q.interval_ms  <= cfg_wdata_i;
        CFG_TOTAL_ENABLE: cfg_q.total_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Front: edge filtering and counting happen here, in the cycle an item is accepted.
  fepc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .pin_level_i    (s_axis_tdata[0]),
    .time_us_i      (s_axis_tdata[TIME_WIDTH:1]),
    .queue_status_i (queue_status),
    .push_o         (push),
    .job_o          (push_job)
  );

  // Read jobs wait here while the rate unit is busy.
  fepc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (queue_status)
  );

  // Back: rate scaling and the result register.
  fepc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .interval_ms_i   (cfg_q.interval_ms),
    .queue_status_i  (queue_status),
    .job_i           (pop_job),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .delta_count_o   (delta_count),
    .rate_q8_o       (rate_q8),
    .running_total_o (running_total)
  );

  assign m_axis_tdata = {running_total, rate_q8, delta_count};

endmodule
